>>> rtl/core/text_mode_glyph_row_renderer_macros.svh
// Assertion macros used by the checker file of the glyph row renderer.
// No dependencies.
`ifndef TEXT_MODE_GLYPH_ROW_RENDERER_MACROS_SVH
`define TEXT_MODE_GLYPH_ROW_RENDERER_MACROS_SVH

// same-cycle implication
`define TGR_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("glyph row renderer check failed");

// next-cycle implication
`define TGR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("glyph row renderer check failed");

`endif

>>> rtl/core/tgr_pkg.sv
// Types, constants and pixel and address helpers for the text-mode glyph row renderer.
// No dependencies.
`default_nettype none
package tgr_pkg;

    localparam int FONT_W         = 8;
    localparam int FONT_H         = 16;
    localparam int GLYPH_COUNT    = 256;
    localparam int SCREEN_COLUMNS = 80;
    localparam int SCREEN_ROWS    = 25;

    localparam int STORE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int GLYPH_BITS  = FONT_W * FONT_H;
    localparam int ROW_W       = 4;
    localparam int CNT_W       = 5;
    localparam int BUF_W       = 16;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    typedef struct packed {
        logic        operation;
        logic [11:0] font_addr;
        logic [7:0]  font_byte;
        logic [7:0]  glyph;
        logic [7:0]  attribute;
        logic        blink_phase;
        logic [6:0]  cell_x;
        logic [4:0]  cell_y;
    } in_req_t;

    typedef struct packed {
        logic [6:0]  out_cell_x;
        logic [4:0]  out_cell_y;
        logic [3:0]  glyph_row;
        logic [31:0] row_pixels;
        logic        last_row;
    } out_req_t;

    function automatic logic [31:0] expand_row(input logic [FONT_W-1:0] bits,
                                               input logic [3:0] fg,
                                               input logic [3:0] bg);
        logic [31:0] res;
        res = '0;
        for (int j = 0; j < FONT_W; j++) begin
            res[4*j +: 4] = bits[j] ? fg : bg;
        end
        return res;
    endfunction

    function automatic logic [ADDR_W-1:0] glyph_base(input logic [7:0] g);
        logic [ADDR_W+15:0] prod;
        prod = {{ADDR_W{1'b0}}, 8'b0, g} * (ADDR_W+16)'(GLYPH_BITS);
        return prod[ADDR_W+2:3];
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/text_mode_glyph_row_renderer.sv
// Top level of the text-mode glyph row renderer: font store, row sequencer, output register.
// Depends on tgr_pkg.
//
// A load request writes one byte into the 4096-byte font store. A render request
// streams the glyph bits out of the store one byte per cycle, unless the output
// stalls, through a small bit buffer and returns FONT_H row results, top row first,
// the last flagged. The single font-store read port sets the pace: one byte per
// cycle, which at FONT_W = 8 is one row per cycle. No new request is taken from
// acceptance of a render until its last row is emitted. The font store has no reset;
// a glyph must be loaded before it is rendered.
`default_nettype none
module text_mode_glyph_row_renderer (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    input  tgr_pkg::in_req_t  s_req,
    output logic              m_valid,
    input  wire               m_ready,
    output tgr_pkg::out_req_t m_data
);
    import tgr_pkg::*;

    logic [7:0]        font_mem [STORE_DEPTH];
    logic [7:0]        rdata_reg;

    state_t            state_reg, state_next;
    logic              pend_reg, pend_next;
    logic              m_valid_reg, m_valid_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [CNT_W-2:0]  cnt_reg, cnt_next;
    logic [BUF_W-1:0]  buf_reg, buf_next;
    logic [3:0]        row_reg, row_next;
    logic [3:0]        fg_reg, bg_reg;
    logic [6:0]        cx_reg;
    logic [4:0]        cy_reg;
    out_req_t          out_reg;

    logic              accept, do_load, do_render;
    logic [BUF_W-1:0]  view;
    logic [CNT_W-1:0]  avail, after;
    logic              out_free, emit, last, rd_en;
    logic [3:0]        fg_in, bg_in;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign do_load   = accept && (s_req.operation == OP_LOAD);
    assign do_render = accept && (s_req.operation == OP_RENDER);

    always_ff @(posedge aclk) begin
        if (do_load) begin
            font_mem[s_req.font_addr] <= s_req.font_byte;
        end
        if (rd_en) begin
            rdata_reg <= font_mem[addr_reg];
        end
    end

    always_comb begin
        bg_in = s_req.attribute[7:4];
        fg_in = s_req.attribute[3:0];
        if (s_req.attribute[7]) begin
            bg_in = {1'b0, s_req.attribute[6:4]};
            if (s_req.blink_phase) begin
                fg_in = bg_in;
            end
        end
    end

    always_comb begin
        view     = pend_reg ? (buf_reg | ({{(BUF_W-8){1'b0}}, rdata_reg} << cnt_reg)) : buf_reg;
        avail    = {1'b0, cnt_reg} + (pend_reg ? CNT_W'(8) : CNT_W'(0));
        out_free = !m_valid_reg || m_ready;
        last     = (row_reg == 4'(FONT_H - 1));
        emit     = (state_reg == ST_RUN) && (avail >= CNT_W'(FONT_W)) && out_free;
        after    = emit ? (avail - CNT_W'(FONT_W)) : avail;
        rd_en    = (state_reg == ST_RUN) && (after < CNT_W'(FONT_W)) && !(emit && last);

        buf_next     = emit ? (view >> FONT_W) : view;
        cnt_next     = after[CNT_W-2:0];
        pend_next    = rd_en;
        addr_next    = rd_en ? addr_reg + 1'b1 : addr_reg;
        row_next     = emit ? row_reg + 1'b1 : row_reg;
        state_next   = state_reg;
        m_valid_next = emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

        unique case (state_reg)
            ST_IDLE: begin
                if (do_render) begin
                    state_next = ST_RUN;
                    addr_next  = glyph_base(s_req.glyph);
                    cnt_next   = '0;
                    buf_next   = '0;
                    pend_next  = 1'b0;
                    row_next   = '0;
                end
            end
            ST_RUN: begin
                if (emit && last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
        cnt_reg  <= cnt_next;
        buf_reg  <= buf_next;
        row_reg  <= row_next;
        if (do_render) begin
            fg_reg <= fg_in;
            bg_reg <= bg_in;
            cx_reg <= s_req.cell_x;
            cy_reg <= s_req.cell_y;
        end
        if (emit) begin
            out_reg.out_cell_x <= cx_reg;
            out_reg.out_cell_y <= cy_reg;
            out_reg.glyph_row  <= row_reg;
            out_reg.row_pixels <= expand_row(view[FONT_W-1:0], fg_reg, bg_reg);
            out_reg.last_row   <= last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule
`default_nettype wire

>>> rtl/core/tgr_checker.sv
// Port-level checks for the glyph row renderer, bound to the top level.
// Depends on tgr_pkg and text_mode_glyph_row_renderer_macros.svh.
`default_nettype none
`include "text_mode_glyph_row_renderer_macros.svh"
module tgr_checker (
    input wire               aclk,
    input wire               aresetn,
    input wire               s_valid,
    input wire               s_ready,
    input tgr_pkg::in_req_t  s_req,
    input wire               m_valid,
    input wire               m_ready,
    input tgr_pkg::out_req_t m_data
);
    import tgr_pkg::*;

    // a stalled result request holds
    `TGR_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    // a render keeps the input side closed
    `TGR_ASSERT_NEXT(a_render_busy, aclk, aresetn, s_valid && s_ready && (s_req.operation == OP_RENDER), !s_ready)
    // mid-cell rows mean the cell is still in progress
    `TGR_ASSERT_NOW(a_mid_busy, aclk, aresetn, m_valid && !m_data.last_row, !s_ready)
    // last flag only on the bottom row
    `TGR_ASSERT_NOW(a_last_row, aclk, aresetn, m_valid && m_data.last_row, m_data.glyph_row == 4'(FONT_H - 1))

endmodule

bind text_mode_glyph_row_renderer tgr_checker u_tgr_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_req   (s_req),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire
